// ----- rtl/core/isc_pkg.sv -----
// ---------------------------------------------------------------------------
// isc_pkg
// Shared widths, register indexes, reset values and status codes for the
// inverter status classifier.
// ---------------------------------------------------------------------------
package isc_pkg;

   localparam int unsigned TIME_W   = 32;
   localparam int unsigned CFG_W    = 24;
   localparam int unsigned LEVEL_W  = 10;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_IDX_W = 3;

   // beat layouts, padded to whole bytes
   localparam int unsigned REQ_W = 48;
   localparam int unsigned RSP_W = 40;
   localparam int unsigned RSP_USED_W = STATUS_W + TIME_W;

   typedef logic [TIME_W-1:0]    time_type;
   typedef logic [CFG_W-1:0]     cfg_type;
   typedef logic [LEVEL_W-1:0]   level_type;
   typedef logic [STATUS_W-1:0]  status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam status_type ST_INIT      = 2'd0;
   localparam status_type ST_ADJUSTING = 2'd1;
   localparam status_type ST_LOCKED    = 2'd2;
   localparam status_type ST_ERROR     = 2'd3;

   localparam csr_idx_type REG_LOCK_TIME   = 3'd0;
   localparam csr_idx_type REG_ADJ_LOW     = 3'd1;
   localparam csr_idx_type REG_ADJ_HIGH    = 3'd2;
   localparam csr_idx_type REG_ERR_THRESH  = 3'd3;
   localparam csr_idx_type REG_ERR_TIME    = 3'd4;

   localparam cfg_type   RST_LOCK_TIME  = 24'd5000;
   localparam cfg_type   RST_ADJ_LOW    = 24'd100;
   localparam cfg_type   RST_ADJ_HIGH   = 24'd3000;
   localparam level_type RST_ERR_THRESH = 10'd512;
   localparam cfg_type   RST_ERR_TIME   = 24'd5000;

endpackage

// ----- rtl/core/inverter_status_classifier_core.sv -----
// ---------------------------------------------------------------------------
// inverter_status_classifier_core
// Classifies inverter status (init, adjusting, locked, error) from sampled
// run and error lines, one status beat per sample beat.
// ---------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_tvalid/tready  | now_ms, run_level, error_level
//  rsp     | out       | rsp_tvalid/tready  | tracker_status, last_pulse_ms
//  csr     | in        | csr_valid/ready    | register index, write data
//
//  one sample per cycle sustained while rsp takes results; a result is offered
//  once its sample has passed the input register, then the result register.
//  the state update is one pass of subtract-compare logic between the two.
//  rsp stall holds the result register; req_tready drops only while both
//  registers are full and the result is not taken.
//  synchronous active-high reset clears state and loads register defaults.
// ---------------------------------------------------------------------------
module inverter_status_classifier_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // [31:0] now_ms, [32] run_level, [42:33] error_level, [47:43] zero
   input  logic [isc_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // [1:0] tracker_status, [33:2] last_pulse_ms, [39:34] zero
   output logic [isc_pkg::RSP_W-1:0] rsp_tdata,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [isc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [isc_pkg::CFG_W-1:0] csr_data
);
   import isc_pkg::*;

   // configuration registers
   cfg_type   lock_time_ff,  lock_time_in;
   cfg_type   adj_low_ff,    adj_low_in;
   cfg_type   adj_high_ff,   adj_high_in;
   level_type err_thresh_ff, err_thresh_in;
   cfg_type   err_time_ff,   err_time_in;

   // input register
   logic      in_valid_ff, in_valid_in;
   time_type  now_ff,      now_in;
   logic      run_ff,      run_in;
   level_type level_ff,    level_in;

   // classifier state
   time_type   run_since_ff,   run_since_in;
   time_type   pulse_begin_ff, pulse_begin_in;
   time_type   pulse_len_ff,   pulse_len_in;
   time_type   err_since_ff,   err_since_in;
   status_type status_ff,      status_in;

   // result register
   logic       out_valid_ff, out_valid_in;
   status_type out_status_ff, out_status_in;
   time_type   out_pulse_ff,  out_pulse_in;

   logic     advance;
   logic     req_take;
   time_type run_age;
   time_type err_age;
   logic     err_high;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take  = req_tvalid && req_tready;
   assign csr_ready = 1'b1;

   always_comb begin
      lock_time_in  = lock_time_ff;
      adj_low_in    = adj_low_ff;
      adj_high_in   = adj_high_ff;
      err_thresh_in = err_thresh_ff;
      err_time_in   = err_time_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_LOCK_TIME:  lock_time_in  = csr_data;
            REG_ADJ_LOW:    adj_low_in    = csr_data;
            REG_ADJ_HIGH:   adj_high_in   = csr_data;
            REG_ERR_THRESH: err_thresh_in = csr_data[LEVEL_W-1:0];
            REG_ERR_TIME:   err_time_in   = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      in_valid_in = in_valid_ff;
      now_in      = now_ff;
      run_in      = run_ff;
      level_in    = level_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         now_in      = req_tdata[TIME_W-1:0];
         run_in      = req_tdata[TIME_W];
         level_in    = req_tdata[TIME_W+LEVEL_W:TIME_W+1];
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // wrapping ages of the run-high and error-high stretches
   assign run_age  = now_ff - run_since_ff;
   assign err_age  = now_ff - err_since_ff;
   assign err_high = level_ff > err_thresh_ff;

   always_comb begin
      run_since_in   = run_since_ff;
      pulse_begin_in = pulse_begin_ff;
      pulse_len_in   = pulse_len_ff;
      err_since_in   = err_since_ff;
      status_in      = status_ff;
      if (advance) begin
         if (run_ff) begin
            if (run_age > TIME_W'(lock_time_ff)) status_in = ST_LOCKED;
            // a zero begin stamp means no pulse is open
            if (pulse_begin_ff == '0) pulse_begin_in = now_ff;
         end else begin
            run_since_in = now_ff;
            if (pulse_begin_ff != '0) begin
               pulse_len_in   = now_ff - pulse_begin_ff;
               pulse_begin_in = '0;
            end
            if (pulse_len_in > TIME_W'(adj_low_ff) && pulse_len_in < TIME_W'(adj_high_ff))
               status_in = ST_ADJUSTING;
         end
         if (err_high) begin
            if (err_age > TIME_W'(err_time_ff)) status_in = ST_ERROR;
         end else begin
            err_since_in = now_ff;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_pulse_in  = out_pulse_ff;
      if (advance) begin
         out_valid_in  = 1'b1;
         out_status_in = status_in;
         out_pulse_in  = pulse_len_in;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lock_time_ff   <= RST_LOCK_TIME;
         adj_low_ff     <= RST_ADJ_LOW;
         adj_high_ff    <= RST_ADJ_HIGH;
         err_thresh_ff  <= RST_ERR_THRESH;
         err_time_ff    <= RST_ERR_TIME;
         in_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
         run_since_ff   <= '0;
         pulse_begin_ff <= '0;
         pulse_len_ff   <= '0;
         err_since_ff   <= '0;
         status_ff      <= ST_INIT;
      end else begin
         lock_time_ff   <= lock_time_in;
         adj_low_ff     <= adj_low_in;
         adj_high_ff    <= adj_high_in;
         err_thresh_ff  <= err_thresh_in;
         err_time_ff    <= err_time_in;
         in_valid_ff    <= in_valid_in;
         out_valid_ff   <= out_valid_in;
         run_since_ff   <= run_since_in;
         pulse_begin_ff <= pulse_begin_in;
         pulse_len_ff   <= pulse_len_in;
         err_since_ff   <= err_since_in;
         status_ff      <= status_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      now_ff        <= now_in;
      run_ff        <= run_in;
      level_ff      <= level_in;
      out_status_ff <= out_status_in;
      out_pulse_ff  <= out_pulse_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(RSP_W-RSP_USED_W)'(0), out_pulse_ff, out_status_ff};

endmodule

// ----- rtl/core/isc_checker.sv -----
// ---------------------------------------------------------------------------
// isc_checker
// Port-level checks on the classifier core, bound into every core instance.
// ---------------------------------------------------------------------------
module isc_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [isc_pkg::RSP_W-1:0] rsp_tdata
);
   import isc_pkg::*;

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   // no result beat straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // input backpressure only comes from a stalled result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req stalled without rsp stall");

   // an accepted sample shows up as a result when rsp keeps taking
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && rsp_tready ##1 rsp_tready |=> rsp_tvalid)
      else $error("result beat missing");

   // pad bits of the result beat stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_W-1:RSP_USED_W] == '0)
      else $error("rsp pad bits set");

endmodule

bind inverter_status_classifier_core isc_checker u_isc_checker (.*);

// ----- sim/inverter_status_classifier_checker.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// inverter_status_classifier_checker
// Watches the sample, status and register channels of the classifier core.
// Keeps its own copy of the tracker state and the registers, works out the
// status beat due for every accepted sample and compares each status beat
// field by field against the oldest one due.
// ---------------------------------------------------------------------------
module inverter_status_classifier_checker (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   input  logic                          req_tready,
   input  logic [isc_pkg::REQ_W-1:0]     req_tdata,
   input  logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   input  logic [isc_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_valid,
   input  logic                          csr_ready,
   input  isc_pkg::csr_idx_type          csr_index,
   input  isc_pkg::cfg_type              csr_data,
   output int unsigned                   mismatch_count,
   output int unsigned                   results_pending
);
   import isc_pkg::*;

   typedef struct packed {
      status_type status;
      time_type   pulse;
   } status_beat_type;

   // register copies
   cfg_type   lock_limit;
   cfg_type   adj_low;
   cfg_type   adj_high;
   level_type err_thresh;
   cfg_type   err_limit;

   // tracker state
   time_type   run_since;
   time_type   pulse_open;
   time_type   pulse_measured;
   time_type   err_since;
   status_type status_now;

   status_beat_type status_due_q[$];
   int unsigned     fail_total = 0;

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      fail_total++;
      $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
   endtask

   task automatic predict_status(input time_type now, input logic run, input level_type lvl);
      status_beat_type due;
      time_type        span;
      if (run) begin
         span = now - run_since;
         if (span > time_type'(lock_limit)) status_now = ST_LOCKED;
      end else begin
         run_since = now;
      end
      if (run) begin
         // an open pulse stamped at zero reads as closed and reopens later
         if (pulse_open == '0) pulse_open = now;
      end else begin
         if (pulse_open != '0) begin
            pulse_measured = now - pulse_open;
            pulse_open     = '0;
         end
         if (pulse_measured > time_type'(adj_low) && pulse_measured < time_type'(adj_high))
            status_now = ST_ADJUSTING;
      end
      if (lvl > err_thresh) begin
         span = now - err_since;
         if (span > time_type'(err_limit)) status_now = ST_ERROR;
      end else begin
         err_since = now;
      end
      due.status = status_now;
      due.pulse  = pulse_measured;
      status_due_q.push_back(due);
   endtask

   always @(posedge clock) begin
      status_beat_type due;
      if (reset) begin
         lock_limit     = RST_LOCK_TIME;
         adj_low        = RST_ADJ_LOW;
         adj_high       = RST_ADJ_HIGH;
         err_thresh     = RST_ERR_THRESH;
         err_limit      = RST_ERR_TIME;
         run_since      = '0;
         pulse_open     = '0;
         pulse_measured = '0;
         err_since      = '0;
         status_now     = ST_INIT;
         status_due_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_LOCK_TIME:  lock_limit = csr_data;
               REG_ADJ_LOW:    adj_low    = csr_data;
               REG_ADJ_HIGH:   adj_high   = csr_data;
               REG_ERR_THRESH: err_thresh = csr_data[LEVEL_W-1:0];
               REG_ERR_TIME:   err_limit  = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_status(req_tdata[31:0], req_tdata[32], req_tdata[42:33]);
         if (rsp_tvalid && rsp_tready) begin
            if (status_due_q.size() == 0) begin
               report_mismatch("unexpected status beat", 64'(rsp_tdata), '0);
            end else begin
               due = status_due_q.pop_front();
               if (rsp_tdata[1:0] !== due.status)
                  report_mismatch("tracker_status", 64'(rsp_tdata[1:0]), 64'(due.status));
               if (rsp_tdata[33:2] !== due.pulse)
                  report_mismatch("last_pulse_ms", 64'(rsp_tdata[33:2]), 64'(due.pulse));
            end
         end
      end
      mismatch_count  <= fail_total;
      results_pending <= status_due_q.size();
   end

endmodule

// ----- sim/inverter_status_classifier_core_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// inverter_status_classifier_core_tb
// Drives sample beats and register writes into the classifier core: a short
// directed run over wrap, zero-stamped pulses, empty adjust windows and wide
// writes, then random run and error stretches under several register
// settings, with random idling on both sides and one long status stall.
// ---------------------------------------------------------------------------
module inverter_status_classifier_core_tb;
   import isc_pkg::*;

   localparam csr_idx_type REG_SPARE = 3'd5;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   csr_idx_type        csr_index  = '0;
   cfg_type            csr_data   = '0;

   int unsigned mismatch_count;
   int unsigned results_pending;

   logic        calm         = 1'b0;
   logic        hold_request = 1'b0;
   logic        hold_done    = 1'b0;
   int unsigned hold_left    = 0;
   time_type    t_now        = '0;
   level_type   cur_thresh   = RST_ERR_THRESH;

   inverter_status_classifier_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   inverter_status_classifier_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .mismatch_count  (mismatch_count),
      .results_pending (results_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // status receiver: random stalls, plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_left  <= 60;
         hold_done  <= 1'b1;
      end else begin
         rsp_tready <= calm || ($urandom_range(99) >= 13);
      end
   end

   initial begin
      #5ms;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic send_sample(input time_type now, input logic run, input level_type lvl);
      while (!calm && $urandom_range(99) < 13) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'd0, lvl, run, now};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input cfg_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // drain every status beat and idle before touching registers
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic apply_settings(input cfg_type lock, input cfg_type low, input cfg_type high,
                                 input level_type thresh, input cfg_type err_ms);
      wait_idle();
      write_reg(REG_LOCK_TIME, lock);
      write_reg(REG_ADJ_LOW, low);
      write_reg(REG_ADJ_HIGH, high);
      write_reg(REG_ERR_THRESH, cfg_type'(thresh));
      write_reg(REG_ERR_TIME, err_ms);
      csr_valid  <= 1'b0;
      cur_thresh = thresh;
   endtask

   // mostly run and error stretches on a rising clock, some pure noise
   task automatic random_phase(input int unsigned n_items, input int unsigned step_max);
      int unsigned sent;
      int unsigned stretch;
      logic        run;
      logic        err_hot;
      level_type   lvl;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            send_sample($urandom, 1'($urandom_range(1)), level_type'($urandom));
            if ($urandom_range(3) == 0) t_now = $urandom;
            sent++;
         end else begin
            stretch = $urandom_range(16, 1);
            run     = 1'($urandom_range(1));
            err_hot = ($urandom_range(2) != 0);
            repeat (stretch) begin
               if (err_hot && cur_thresh != '1)
                  lvl = level_type'($urandom_range(1023, cur_thresh + 1));
               else if (err_hot)
                  lvl = level_type'($urandom);
               else
                  lvl = level_type'($urandom_range(cur_thresh, 0));
               t_now = t_now + $urandom_range(step_max);
               send_sample(t_now, run, lvl);
               sent++;
            end
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: zero-stamped pulse, adjusting, error, locked, wrap
      send_sample(32'd0, 1'b1, 10'd0);
      send_sample(32'd40, 1'b1, 10'd0);
      send_sample(32'd600, 1'b0, 10'd0);
      send_sample(32'd700, 1'b0, 10'd1023);
      send_sample(32'd5700, 1'b0, 10'd513);
      send_sample(32'd5800, 1'b1, 10'd512);
      send_sample(32'd11000, 1'b1, 10'd0);
      send_sample(32'hFFFF_FF00, 1'b0, 10'd0);
      send_sample(32'hFFFF_FFFF, 1'b1, 10'd0);
      send_sample(32'h0000_01F3, 1'b0, 10'd0);
      send_sample(32'h0000_2000, 1'b1, 10'd1023);
      send_sample(32'hFFFF_FFFF, 1'b1, 10'd1023);

      // empty adjust window, threshold written with bits above its width
      wait_idle();
      write_reg(REG_SPARE, 24'hFF_FFFF);
      write_reg(REG_LOCK_TIME, 24'd50);
      write_reg(REG_ADJ_LOW, 24'd200);
      write_reg(REG_ADJ_HIGH, 24'd201);
      write_reg(REG_ERR_THRESH, 24'hFF_FC00 | 24'd300);
      write_reg(REG_ERR_TIME, 24'd100);
      csr_valid  <= 1'b0;
      cur_thresh = 10'd300;
      send_sample(32'd100, 1'b0, 10'd300);
      send_sample(32'd110, 1'b1, 10'd301);
      send_sample(32'd310, 1'b0, 10'd301);
      send_sample(32'd400, 1'b1, 10'd0);
      send_sample(32'd601, 1'b0, 10'd1023);
      send_sample(32'd800, 1'b0, 10'd1023);

      random_phase(80, 700);

      apply_settings(24'd50, 24'd10, 24'd200, 10'd100, 24'd80);
      calm <= 1'b1;
      random_phase(80, 60);
      calm <= 1'b0;

      apply_settings(24'd0, 24'd0, 24'hFF_FFFF, 10'd0, 24'd0);
      hold_request <= 1'b1;
      random_phase(80, 1000);

      apply_settings(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 10'd1023, 24'hFF_FFFF);
      random_phase(80, 4_000_000);

      apply_settings(cfg_type'($urandom_range(3000)), cfg_type'($urandom_range(500)),
                     cfg_type'($urandom_range(3000)), level_type'($urandom_range(1023)),
                     cfg_type'($urandom_range(3000)));
      random_phase(80, 500);

      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
